FILE: hw/rtl/sdi_pkg.sv
package sdi_pkg;

  localparam int RESPONSE_MAX_DEF = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE    = 2'd3;

  localparam logic [8:0]  WAIT_LIMIT_RST  = 9'd256;
  localparam logic [16:0] RETRY_LIMIT_RST = 17'd65536;
  localparam logic [12:0] BLOCK_LEN_RST   = 13'd512;
  localparam logic [7:0]  PREAMBLE_RST    = 8'd8;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_CMD0     = 4'd1;
  localparam logic [3:0] ERR_CMD8     = 4'd2;
  localparam logic [3:0] ERR_VOLTAGE  = 4'd3;
  localparam logic [3:0] ERR_CMD58    = 4'd4;
  localparam logic [3:0] ERR_CMD55    = 4'd5;
  localparam logic [3:0] ERR_ACMD41   = 4'd6;
  localparam logic [3:0] ERR_ACMD41_TO = 4'd7;
  localparam logic [3:0] ERR_CMD16    = 4'd8;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] CRC_OTHER = 8'h01;
  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY  = 8'h00;
  localparam logic [7:0] R1_V1_CARD = 8'h05;
  localparam logic [7:0] R1_ERR_MASK = 8'hFE;
  localparam logic [7:0] VOLT_MASK = 8'hFC;
  localparam logic [7:0] PWR_MASK  = 8'hC0;
  localparam logic [7:0] ECHO_PATTERN = 8'hAA;
  localparam logic [31:0] CMD8_ARG = 32'h0000_01AA;
  localparam logic [31:0] HCS_ARG  = 32'h4000_0000;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_PRE    = 10'b00_0000_0010,
    PH_CMD0   = 10'b00_0000_0100,
    PH_CMD8   = 10'b00_0000_1000,
    PH_CMD58A = 10'b00_0001_0000,
    PH_CMD55  = 10'b00_0010_0000,
    PH_ACMD41 = 10'b00_0100_0000,
    PH_CMD58B = 10'b00_1000_0000,
    PH_CMD16  = 10'b01_0000_0000,
    PH_DONE   = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [3:0] {
    SUB_SEND = 4'b0001,
    SUB_POLL = 4'b0010,
    SUB_BODY = 4'b0100,
    SUB_TAIL = 4'b1000
  } sub_t;

  typedef struct packed {
    logic [8:0]  wait_limit;
    logic [16:0] retry_limit;
    logic [12:0] block_len;
    logic [7:0]  preamble;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       done_res;
    logic [3:0] error_code;
    logic       card_v2;
  } result_t;

  function automatic logic [7:0] cmd_index(phase_t ph);
    logic [7:0] idx;
    unique case (ph)
      PH_CMD8:             idx = 8'd8;
      PH_CMD58A, PH_CMD58B: idx = 8'd58;
      PH_CMD55:            idx = 8'd55;
      PH_ACMD41:           idx = 8'd41;
      PH_CMD16:            idx = 8'd16;
      default:             idx = 8'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [3:0] error_of(phase_t ph);
    logic [3:0] code;
    unique case (ph)
      PH_CMD0:              code = ERR_CMD0;
      PH_CMD8:              code = ERR_CMD8;
      PH_CMD58A, PH_CMD58B: code = ERR_CMD58;
      PH_CMD55:             code = ERR_CMD55;
      PH_ACMD41:            code = ERR_ACMD41;
      default:              code = ERR_CMD16;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] frame_byte(phase_t ph, logic [2:0] i, logic v2,
                                            logic [12:0] blk);
    logic [31:0] arg;
    logic [7:0]  b;
    if (ph == PH_CMD8)        arg = CMD8_ARG;
    else if (ph == PH_ACMD41) arg = v2 ? HCS_ARG : 32'd0;
    else if (ph == PH_CMD16)  arg = {19'd0, blk};
    else                      arg = 32'd0;
    case (i)
      3'd0:    b = CMD_START | cmd_index(ph);
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (ph == PH_CMD0) ? CRC_CMD0 : ((ph == PH_CMD8) ? CRC_CMD8 : CRC_OTHER);
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/sdi_ifs.sv
interface sdi_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface sdi_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       chip_select;
  logic       done_res;
  logic [3:0] error_code;
  logic       card_v2;

  modport source (output valid, tx_byte, chip_select, done_res, error_code, card_v2,
                  input ready);
  modport sink   (input valid, tx_byte, chip_select, done_res, error_code, card_v2,
                  output ready);
endinterface

FILE: hw/rtl/sdi_seq.sv
module sdi_seq #(
  parameter int RESPONSE_MAX = sdi_pkg::RESPONSE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             opcode,
  input  logic [7:0]       rx_byte,
  input  sdi_pkg::cfg_t    cfg,
  output sdi_pkg::result_t res
);
  import sdi_pkg::*;

  localparam int FBI_W = ($clog2(RESPONSE_MAX + 1) > 3) ? $clog2(RESPONSE_MAX + 1) : 3;
  localparam int PAD_N = 5;

  phase_t             phase, phase_next;
  sub_t               sub, sub_next;
  logic [FBI_W-1:0]   fbi, fbi_next;
  logic [8:0]         wait_cnt, wait_cnt_next;
  logic [16:0]        retry_cnt, retry_cnt_next;
  logic [7:0]         resp [RESPONSE_MAX];
  logic [7:0]         resp_next [RESPONSE_MAX];
  logic [7:0]         resp_pad [PAD_N];
  logic               v2, v2_next;
  logic [3:0]         code, code_next;
  logic [7:0]         tx;
  logic               cs;
  logic [16:0]        retry_inc;
  logic [2:0]         fbi_lo_inc;
  logic               long_rsp;

  // bytes past the stored response read as zero
  for (genvar k = 0; k < PAD_N; k++) begin : g_pad
    if (k < RESPONSE_MAX) begin : g_have
      assign resp_pad[k] = resp[k];
    end else begin : g_zero
      assign resp_pad[k] = 8'd0;
    end
  end

  assign retry_inc  = retry_cnt + 17'd1;
  assign fbi_lo_inc = fbi[2:0] + 3'd1;
  assign long_rsp   = (phase == PH_CMD8) || (phase == PH_CMD58A) || (phase == PH_CMD58B);

  always_comb begin
    phase_next     = phase;
    sub_next       = sub;
    fbi_next       = fbi;
    wait_cnt_next  = wait_cnt;
    retry_cnt_next = retry_cnt;
    resp_next      = resp;
    v2_next        = v2;
    code_next      = code;
    tx             = IDLE_BYTE;
    cs             = 1'b0;

    if (opcode == OP_START) begin
      for (int k = 0; k < RESPONSE_MAX; k++) resp_next[k] = 8'd0;
      v2_next        = 1'b0;
      code_next      = ERR_OK;
      retry_cnt_next = '0;
      fbi_next       = '0;
      sub_next       = SUB_SEND;
      phase_next     = PH_PRE;
      wait_cnt_next  = 9'd1;
    end else begin
      unique case (phase)
        PH_IDLE, PH_DONE: begin
        end
        PH_PRE: begin
          if (wait_cnt < {1'b0, cfg.preamble}) begin
            wait_cnt_next = wait_cnt + 9'd1;
          end else begin
            phase_next = PH_CMD0;
            sub_next   = SUB_SEND;
            fbi_next   = '0;
            tx         = frame_byte(PH_CMD0, 3'd0, v2, cfg.block_len);
            cs         = 1'b1;
          end
        end
        default: begin
          cs = 1'b1;
          unique case (sub)
            SUB_SEND: begin
              if (fbi < FBI_W'(5)) begin
                fbi_next = fbi + FBI_W'(1);
                tx       = frame_byte(phase, fbi_lo_inc, v2, cfg.block_len);
              end else begin
                sub_next      = SUB_POLL;
                wait_cnt_next = 9'd1;
              end
            end
            SUB_POLL: begin
              if (rx_byte == IDLE_BYTE) begin
                if (wait_cnt >= cfg.wait_limit) begin
                  phase_next = PH_DONE;
                  code_next  = error_of(phase);
                  cs         = 1'b0;
                end else begin
                  wait_cnt_next = wait_cnt + 9'd1;
                end
              end else begin
                resp_next[0] = rx_byte;
                if ((rx_byte & R1_ERR_MASK) != 8'd0) begin
                  if (phase == PH_CMD8 && rx_byte == R1_V1_CARD) begin
                    // v1 card: CMD8 is illegal, skip straight to CMD58
                    v2_next    = 1'b0;
                    phase_next = PH_CMD58A;
                    sub_next   = SUB_SEND;
                    fbi_next   = '0;
                    tx         = frame_byte(PH_CMD58A, 3'd0, v2, cfg.block_len);
                  end else begin
                    phase_next = PH_DONE;
                    code_next  = error_of(phase);
                    cs         = 1'b0;
                  end
                end else if (long_rsp && RESPONSE_MAX > 1) begin
                  sub_next = SUB_BODY;
                  fbi_next = FBI_W'(1);
                end else begin
                  sub_next = SUB_TAIL;
                end
              end
            end
            SUB_BODY: begin
              for (int k = 1; k < RESPONSE_MAX; k++) begin
                if (fbi == FBI_W'(k)) resp_next[k] = rx_byte;
              end
              fbi_next = fbi + FBI_W'(1);
              if ((fbi + FBI_W'(1)) >= FBI_W'(RESPONSE_MAX)) sub_next = SUB_TAIL;
            end
            SUB_TAIL: begin
              // judge the response; default is to finish with this command's code
              phase_next = PH_DONE;
              code_next  = error_of(phase);
              cs         = 1'b0;
              unique case (phase)
                PH_CMD0: begin
                  if (resp_pad[0] == R1_IDLE) phase_next = PH_CMD8;
                end
                PH_CMD8: begin
                  if (resp_pad[0] == R1_IDLE) begin
                    if (resp_pad[3] == R1_IDLE && resp_pad[4] == ECHO_PATTERN) begin
                      v2_next    = 1'b1;
                      phase_next = PH_CMD58A;
                    end else begin
                      code_next = ERR_VOLTAGE;
                    end
                  end
                end
                PH_CMD58A: begin
                  if (resp_pad[0] == R1_IDLE && (resp_pad[2] & VOLT_MASK) == VOLT_MASK) begin
                    retry_cnt_next = '0;
                    phase_next     = PH_CMD55;
                  end
                end
                PH_CMD55: begin
                  if (resp_pad[0] == R1_IDLE) phase_next = PH_ACMD41;
                end
                PH_ACMD41: begin
                  if (resp_pad[0] == R1_READY) begin
                    phase_next = PH_CMD58B;
                  end else begin
                    retry_cnt_next = retry_inc;
                    if (retry_inc >= cfg.retry_limit) code_next = ERR_ACMD41_TO;
                    else                              phase_next = PH_CMD55;
                  end
                end
                PH_CMD58B: begin
                  if ((resp_pad[1] & PWR_MASK) == PWR_MASK) phase_next = PH_CMD16;
                end
                default: begin
                  if (resp_pad[0] == R1_READY) code_next = ERR_OK;
                end
              endcase
              if (phase_next != PH_DONE) begin
                sub_next = SUB_SEND;
                fbi_next = '0;
                cs       = 1'b1;
                tx       = frame_byte(phase_next, 3'd0, v2_next, cfg.block_len);
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      sub       <= SUB_SEND;
      fbi       <= '0;
      wait_cnt  <= '0;
      retry_cnt <= '0;
      v2        <= 1'b0;
      code      <= ERR_OK;
      for (int k = 0; k < RESPONSE_MAX; k++) resp[k] <= 8'd0;
    end else if (step) begin
      phase     <= phase_next;
      sub       <= sub_next;
      fbi       <= fbi_next;
      wait_cnt  <= wait_cnt_next;
      retry_cnt <= retry_cnt_next;
      v2        <= v2_next;
      code      <= code_next;
      resp      <= resp_next;
    end
  end

  assign res.tx_byte     = tx;
  assign res.chip_select = cs;
  assign res.done_res    = (phase_next == PH_DONE);
  assign res.error_code  = (phase_next == PH_DONE) ? code_next : ERR_OK;
  assign res.card_v2     = v2_next;

`ifndef ASSERT_OFF
  a_wait_bounded: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PRE && phase != PH_IDLE && phase != PH_DONE && sub == SUB_POLL)
      |-> (wait_cnt <= cfg.wait_limit || wait_cnt == 9'd1))
    else $error("poll count ran past the wait limit");
  a_done_deselect: assert property (@(posedge clk) disable iff (rst)
    (step && phase_next == PH_DONE) |-> (!cs && tx == IDLE_BYTE))
    else $error("finished sequence still selects the card");
`endif

endmodule

FILE: hw/rtl/sd_spi_card_init_core.sv
// SD card SPI-mode power-up sequencer.
// req channel: one transfer per SPI byte slot. opcode start begins the
// sequence; opcode byte carries the byte the card returned on the previous
// exchange. rsp channel: exactly one transfer per req transfer, in order,
// giving the next byte to shift out, the chip-select level, and once the
// sequence ends, done_res with the error code and the v2-card flag.
// A req transfer is captured in the input register when it is taken; its
// answer, formed from that register and the sequencer state, then loads
// the output register that drives rsp. Throughput: one item per cycle
// while rsp does not stall; the sequencer state is updated in the same
// cycle the output register loads, so consecutive items need no gap. In
// use the pace is set by the SPI link: each item is one byte exchange.
// Reset (synchronous, rst high) returns the sequencer to idle and the
// configuration registers to wait limit 256, retry limit 65536, block
// length 512 and preamble 8. A rsp stall holds the output register; the
// input register then fills and req.ready drops until rsp drains.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once
// and are meant for idle periods only.
module sd_spi_card_init_core #(
  parameter int RESPONSE_MAX = sdi_pkg::RESPONSE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sdi_req_if.sink                        req,
  sdi_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [sdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdi_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_rx;
  logic       advance;
  result_t    step_res;
  result_t    out_res;
  logic       out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_limit  <= WAIT_LIMIT_RST;
      cfg.retry_limit <= RETRY_LIMIT_RST;
      cfg.block_len   <= BLOCK_LEN_RST;
      cfg.preamble    <= PREAMBLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAIT_LIMIT:  cfg.wait_limit  <= cfg_data[8:0];
        CFG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[16:0];
        CFG_BLOCK_LEN:   cfg.block_len   <= cfg_data[12:0];
        CFG_PREAMBLE:    cfg.preamble    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // stage 1 moves into the output register whenever that slot is free or
  // being drained this cycle
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_opcode <= req.opcode;
      s1_rx     <= req.rx_byte;
    end
  end

  sdi_seq #(
    .RESPONSE_MAX (RESPONSE_MAX)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_valid && advance),
    .opcode  (s1_opcode),
    .rx_byte (s1_rx),
    .cfg     (cfg),
    .res     (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_res <= step_res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.tx_byte     = out_res.tx_byte;
  assign rsp.chip_select = out_res.chip_select;
  assign rsp.done_res    = out_res.done_res;
  assign rsp.error_code  = out_res.error_code;
  assign rsp.card_v2     = out_res.card_v2;

`ifndef ASSERT_OFF
  a_done_idle_bus: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_res) |-> (!rsp.chip_select && rsp.tx_byte == IDLE_BYTE))
    else $error("done result drives the card");
  a_code_only_when_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.done_res) |-> (rsp.error_code == ERR_OK))
    else $error("error code shown before the sequence ended");
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_opcode) && $stable(s1_rx)))
    else $error("input register lost an item while stalled");
`endif

endmodule
